FILE: hw/rtl/mfmd_pkg.sv
// Shared types, constants and CRC helper for the MFM sector mark deframer.
package mfmd_pkg;

   // CSR map
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ID_MARK   = 2'd0;
   localparam logic [1:0] REG_DATA_MARK = 2'd1;
   localparam logic [1:0] REG_CRC_INIT  = 2'd2;

   localparam logic [31:0] ID_MARK_RESET   = 32'h4489_5554;
   localparam logic [31:0] DATA_MARK_RESET = 32'h4489_5545;
   localparam logic [15:0] CRC_INIT_RESET  = 16'hFFFF;

   // CRC-16/CCITT, MSB first
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [7:0]  SYNC_BYTE      = 8'hA1;
   localparam logic [7:0]  ID_MARK_BYTE   = 8'hFE;
   localparam logic [7:0]  DATA_MARK_BYTE = 8'hFB;
   localparam logic [2:0]  PRESET_STEPS   = 3'd4;   // A1 A1 A1 + mark byte

   // Field layout
   localparam logic [10:0] ID_FIELD_BYTES    = 11'd6;
   localparam logic [10:0] CRC_BYTES         = 11'd2;
   localparam logic [10:0] SIZE_CODE_INDEX   = 11'd3;
   localparam int          BASE_SECTOR_BYTES = 128;
   localparam int          MAX_FIELD_BYTES   = 2047;

   // Result kinds
   localparam logic [1:0] KIND_ID     = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_ORPHAN = 2'd2;

   // Decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic mfm_bit;
      logic id_match;
      logic data_match;
   } bit_event_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_cur, input logic [7:0] b);
      logic [15:0] c;
      c = crc_cur ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/mfmd_if.sv
// Valid/ready channel interfaces for the bit input and the byte result.
interface mfmd_req_if;
   logic valid;
   logic ready;
   logic mfm_bit;

   modport source (output valid, output mfm_bit, input ready);
   modport sink   (input valid, input mfm_bit, output ready);
endinterface

interface mfmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  field_kind;
   logic [7:0]  byte_value;
   logic [10:0] byte_index;
   logic        last_byte;
   logic        crc_ok;

   modport source (output valid, output field_kind, output byte_value, output byte_index,
                   output last_byte, output crc_ok, input ready);
   modport sink   (input valid, input field_kind, input byte_value, input byte_index,
                   input last_byte, input crc_ok, output ready);
endinterface

FILE: hw/rtl/mfmd_front.sv
// Front end: 32-bit bit window and address mark compare.
module mfmd_front (
   input  logic                   clock,
   input  logic                   reset,
   mfmd_req_if.sink               req_bus,
   input  logic [31:0]            id_mark_pattern,
   input  logic [31:0]            data_mark_pattern,
   input  logic                   queue_full,
   output logic                   push,
   output mfmd_pkg::bit_event_type push_event
);
   import mfmd_pkg::*;

   logic [31:0] window_ff;
   logic [31:0] window_in;

   assign req_bus.ready = ~queue_full;
   assign push          = req_bus.valid & ~queue_full;
   assign window_in     = {window_ff[30:0], req_bus.mfm_bit};

   always_comb begin
      push_event.mfm_bit    = req_bus.mfm_bit;
      push_event.id_match   = (window_in == id_mark_pattern);
      push_event.data_match = (window_in == data_mark_pattern);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (push) begin
         window_ff <= window_in;
      end
   end

endmodule

FILE: hw/rtl/mfmd_queue.sv
// Short FIFO of classified bit beats between front and back end.
module mfmd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mfmd_pkg::bit_event_type push_event,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output mfmd_pkg::bit_event_type pop_event
);
   import mfmd_pkg::*;

   bit_event_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;
   logic                  do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_event = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & pop_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop_valid && !do_pop && !push |=> pop_valid && $stable(pop_event))
      else $error("queue head changed without pop");

   assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule

FILE: hw/rtl/mfmd_back.sv
// Back end: field sequencing, MFM cell decode, CRC check and result register.
module mfmd_back #(
   parameter int MAX_SIZE_CODE = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  mfmd_pkg::bit_event_type q_event,
   output logic                    pop,
   input  logic [15:0]             crc_init,
   mfmd_rsp_if.source              rsp_bus
);
   import mfmd_pkg::*;

   localparam int LEN_W = $clog2(BASE_SECTOR_BYTES) + MAX_SIZE_CODE + 1;

   typedef enum logic [1:0] {MODE_IDLE, MODE_ID, MODE_DATA} mode_type;

   mode_type    mode_ff, mode_in;
   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  shift_ff, shift_in;
   logic [10:0] done_ff, done_in;
   logic [10:0] total_ff, total_in;
   logic [10:0] armed_ff, armed_in;
   logic [15:0] crc_ff, crc_in;
   logic [2:0]  preset_ff, preset_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  value_ff, value_in;
   logic [10:0] index_ff, index_in;
   logic        last_ff, last_in;
   logic        ok_ff, ok_in;

   logic [7:0]       shift_next;
   logic [15:0]      crc_next;
   logic [7:0]       mark_byte;
   logic             byte_last;
   logic [LEN_W-1:0] len_wide;
   logic             size_ok;

   assign mark_byte = (mode_ff == MODE_DATA) ? DATA_MARK_BYTE : ID_MARK_BYTE;
   assign pop       = q_valid & (~rsp_valid_ff | rsp_bus.ready);

   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      done_in      = done_ff;
      total_in     = total_ff;
      armed_in     = armed_ff;
      crc_in       = crc_ff;
      preset_in    = preset_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      ok_in        = ok_ff;

      shift_next = phase_ff[0] ? {shift_ff[6:0], q_event.mfm_bit} : shift_ff;
      crc_next   = crc_byte(crc_ff, shift_next);
      byte_last  = ({1'b0, done_ff} + 12'd1) >= {1'b0, total_ff};
      size_ok    = ({24'd0, shift_next} <= 32'(MAX_SIZE_CODE));
      len_wide   = size_ok ? (LEN_W'(BASE_SECTOR_BYTES) << shift_next[2:0]) : '0;

      // mark preset runs one byte a cycle, done long before the first cell ends
      if (preset_ff != '0) begin
         crc_in    = crc_byte(crc_ff, (preset_ff == 3'd1) ? mark_byte : SYNC_BYTE);
         preset_in = preset_ff - 3'd1;
      end

      if (pop) begin
         if (q_event.id_match) begin
            armed_in  = '0;
            mode_in   = MODE_ID;
            total_in  = ID_FIELD_BYTES;
            done_in   = '0;
            phase_in  = '0;
            shift_in  = '0;
            crc_in    = crc_init;
            preset_in = PRESET_STEPS;
         end else if (q_event.data_match) begin
            if (armed_ff != '0) begin
               mode_in   = MODE_DATA;
               total_in  = armed_ff + CRC_BYTES;
               armed_in  = '0;
               done_in   = '0;
               phase_in  = '0;
               shift_in  = '0;
               crc_in    = crc_init;
               preset_in = PRESET_STEPS;
            end else begin
               // orphan data mark
               mode_in      = MODE_IDLE;
               rsp_valid_in = 1'b1;
               kind_in      = KIND_ORPHAN;
               value_in     = '0;
               index_in     = '0;
               last_in      = 1'b1;
               ok_in        = 1'b0;
            end
         end else if (mode_ff != MODE_IDLE) begin
            if (phase_ff != 4'hF) begin
               phase_in = phase_ff + 4'd1;
               shift_in = shift_next;
            end else begin
               phase_in = '0;
               shift_in = '0;
               crc_in   = crc_next;
               if (mode_ff == MODE_ID && done_ff == SIZE_CODE_INDEX) begin
                  if (size_ok && (32'(len_wide) + 32'(CRC_BYTES) <= 32'(MAX_FIELD_BYTES))) begin
                     armed_in = 11'(len_wide);
                  end else begin
                     armed_in = '0;
                  end
               end
               rsp_valid_in = 1'b1;
               kind_in      = (mode_ff == MODE_ID) ? KIND_ID : KIND_DATA;
               value_in     = shift_next;
               index_in     = done_ff;
               last_in      = byte_last;
               ok_in        = byte_last && (crc_next == '0);
               done_in      = done_ff + 11'd1;
               if (byte_last) begin
                  mode_in = MODE_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= '0;
         shift_ff     <= '0;
         done_ff      <= '0;
         total_ff     <= '0;
         armed_ff     <= '0;
         crc_ff       <= CRC_INIT_RESET;
         preset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         done_ff      <= done_in;
         total_ff     <= total_in;
         armed_ff     <= armed_in;
         crc_ff       <= crc_in;
         preset_ff    <= preset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      value_ff <= value_in;
      index_ff <= index_in;
      last_ff  <= last_in;
      ok_ff    <= ok_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.field_kind = kind_ff;
   assign rsp_bus.byte_value = value_ff;
   assign rsp_bus.byte_index = index_ff;
   assign rsp_bus.last_byte  = last_ff;
   assign rsp_bus.crc_ok     = ok_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_ORPHAN |-> last_ff && !ok_ff && index_ff == '0)
      else $error("malformed orphan mark beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ok_ff |-> last_ff)
      else $error("crc_ok on non-final byte");

   assert property (@(posedge clock) disable iff (reset)
      preset_ff != '0 |-> phase_ff < 4'd12 && done_ff == '0)
      else $error("CRC preset still running at cell end");

endmodule

FILE: hw/rtl/mfm_sector_mark_deframer.sv
// Top level of the MFM sector mark deframer: CSRs and front/queue/back wiring.
//
// Usage:
//   req_bus carries one raw MFM channel bit per beat (valid/ready). The bits
//   shift into a 32-bit window; a match with the ID or data mark pattern
//   starts a field, whose 16-bit cells are decoded into bytes.
//   rsp_bus carries one beat per decoded byte (kind, value, index, last,
//   crc_ok on the last byte) and one beat for a data mark with no armed ID.
//   The APB port holds the two mark patterns and the CRC start value; write
//   it only while the block is idle.
// Throughput: one bit per cycle while rsp_bus.ready takes each result. The
//   back end retires one queued bit per cycle unless a result waits on ready.
// Path: the bit that completes the byte or hits the orphan mark passes
//   through the queue and then the result register, which drives rsp_bus.
// Reset: window, field state and queue clear, nothing is armed, and the
//   registers return to their default patterns and CRC start value.
// Stall: when rsp_bus.ready is low the result register holds; bits keep
//   being taken until the four-entry queue fills, then req_bus.ready drops.
module mfm_sector_mark_deframer #(
   parameter int MAX_SIZE_CODE = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   mfmd_req_if.sink                        req_bus,
   mfmd_rsp_if.source                      rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mfmd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import mfmd_pkg::*;

   // configuration registers
   logic [31:0] id_mark_ff;
   logic [31:0] data_mark_ff;
   logic [15:0] crc_init_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   // front to queue to back
   logic          push;
   bit_event_type push_event;
   logic          queue_full;
   logic          pop;
   logic          pop_valid;
   bit_event_type pop_event;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         id_mark_ff   <= ID_MARK_RESET;
         data_mark_ff <= DATA_MARK_RESET;
         crc_init_ff  <= CRC_INIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ID_MARK:   id_mark_ff   <= pwdata;
            REG_DATA_MARK: data_mark_ff <= pwdata;
            REG_CRC_INIT:  crc_init_ff  <= pwdata[15:0];
            default:       ;   // unmapped, write ignored
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ID_MARK:   prdata = id_mark_ff;
         REG_DATA_MARK: prdata = data_mark_ff;
         REG_CRC_INIT:  prdata = {16'd0, crc_init_ff};
         default:       prdata = '0;
      endcase
   end

   // classify each bit against the mark patterns
   mfmd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_bus           (req_bus),
      .id_mark_pattern   (id_mark_ff),
      .data_mark_pattern (data_mark_ff),
      .queue_full        (queue_full),
      .push              (push),
      .push_event        (push_event)
   );

   // slack so a stalled result does not stop bit intake at once
   mfmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_event  (pop_event)
   );

   // field decode, CRC, result register
   mfmd_back #(
      .MAX_SIZE_CODE (MAX_SIZE_CODE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (pop_valid),
      .q_event  (pop_event),
      .pop      (pop),
      .crc_init (crc_init_ff),
      .rsp_bus  (rsp_bus)
   );

endmodule
